// ===== sv/acrms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acrms_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int RMS_W      = 16;
   localparam int MEAN_W     = 20;
   localparam int APP_W      = 24;
   localparam int PF_W       = 16;
   localparam int FREQ_W     = 18;
   localparam int PERIOD_W   = 16;
   localparam int MS_W       = 32;

   // configuration registers
   localparam int THRESH_W   = 16;
   localparam int CUR_W      = 8;
   localparam int MAXP_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd65535;
   localparam logic [CUR_W-1:0]    CUR_RESET    = 8'd20;
   localparam logic [MAXP_W-1:0]   MAXP_RESET   = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESH     = 2'd0,
      CSR_CURRENT    = 2'd1,
      CSR_MAX_PERIOD = 2'd2
   } csr_index_type;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // frame length default
   localparam int DEF_FRAME_SAMPLES = 12;

   // square root unit: radicand and root widths
   localparam int RAD_W  = 32;
   localparam int ROOT_W = 16;

   // scaling
   localparam int RMS_FRAC_SHIFT = 8;       // 16x on the root means 256x on the radicand
   localparam int PF_SHIFT       = 19;      // 2^15 for Q1.15 and 2^4 for the Q.4 rms
   localparam int PF_MAX         = 32768;
   localparam int FREQ_SCALE     = 256000;  // 1000 Hz*ms in Q.8

endpackage

`default_nettype wire

// ===== sv/acrms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface acrms_req_if;
   import acrms_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [SAMPLE_W-1:0] sample;
   logic                cross_level;

   modport source (output valid, output kind, output sample, output cross_level,
                   input ready);
   modport sink   (input valid, input kind, input sample, input cross_level,
                   output ready);
endinterface

interface acrms_rsp_if;
   import acrms_pkg::*;

   logic                valid;
   logic                ready;
   logic [RMS_W-1:0]    rms_voltage;
   logic [MEAN_W-1:0]   mean_power;
   logic [APP_W-1:0]    apparent_power;
   logic [PF_W-1:0]     power_factor;
   logic [FREQ_W-1:0]   frequency;
   logic [PERIOD_W-1:0] period_ms;
   logic                ac_present;
   logic                relay_active;

   modport source (output valid, output rms_voltage, output mean_power,
                   output apparent_power, output power_factor, output frequency,
                   output period_ms, output ac_present, output relay_active,
                   input ready);
   modport sink   (input valid, input rms_voltage, input mean_power,
                   input apparent_power, input power_factor, input frequency,
                   input period_ms, input ac_present, input relay_active,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/acrms_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module acrms_div #(
   parameter int DIVIDEND_W = 36,
   parameter int DIVISOR_W  = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    cand;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      cand = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff = cand - {1'b0, dvs_ff};
      fits = cand >= {1'b0, dvs_ff};
      rem_in = fits ? diff[DIVISOR_W-1:0] : cand[DIVISOR_W-1:0];
      // quotient bits shift in behind the dividend bits
      dvd_in = {dvd_ff[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(DIVIDEND_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            dvd_ff <= dvd_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// ===== sv/acrms_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// digit-by-digit integer square root, two radicand bits per cycle
module acrms_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [acrms_pkg::RAD_W-1:0]  radicand,
   output logic                              done,
   output logic [acrms_pkg::ROOT_W-1:0]      root
);
   import acrms_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;
   logic              fits;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_sh - trial;
      fits    = rem_sh >= trial;
      rem_in  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_in = {root_ff[ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= !start && busy_ff && (step_ff == STEP_W'(ROOT_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= rem_in;
            root_ff <= root_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ===== sv/ac_line_rms_monitor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// req       in   valid / ready      kind, sample, cross_level
// rsp       out  valid / ready      rms, powers, power factor, frequency, period, flags
// csr       in   csr_write_en       csr_index, csr_wdata
//
// a tick only advances the millisecond counter; a sample is squared bit-serially.
// the last sample of a frame then runs the serial divider two to four times
// (DIV_W = 32 + clog2(FRAME_SAMPLES) dividend bits) and the square root once.
// reset is synchronous; it clears accumulators, timers, held values and
// restores the register defaults. req is ready only between items; a finished
// word waits in the rsp register and blocks only the next frame end.
module ac_line_rms_monitor_unit #(
   parameter int FRAME_SAMPLES = acrms_pkg::DEF_FRAME_SAMPLES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   acrms_req_if.sink                              req,
   acrms_rsp_if.source                            rsp,
   input  wire logic                              csr_write_en,
   input  wire logic [acrms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [acrms_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import acrms_pkg::*;

   localparam int FS_LOG = $clog2(FRAME_SAMPLES);
   localparam int IDX_W  = $clog2(FRAME_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_W + FS_LOG;
   localparam int PROD_W = 2 * SAMPLE_W;
   localparam int SQ_W   = PROD_W + FS_LOG;
   localparam int DIV_W  = SQ_W + RMS_FRAC_SHIFT;
   localparam int DVS_W  = RMS_W + FS_LOG;
   localparam int BIT_W  = $clog2(SAMPLE_W);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIV_MS,
      ST_SQRT,
      ST_MUL,
      ST_DIV_MEAN,
      ST_DIV_PF,
      ST_CROSS,
      ST_DIV_FREQ,
      ST_OUT
   } state_type;

   state_type state_ff;

   logic [THRESH_W-1:0] thresh_ff;
   logic [CUR_W-1:0]    cur_ff;
   logic [MAXP_W-1:0]   maxp_ff;

   logic [IDX_W-1:0]    frame_idx_ff;
   logic [SUM_W-1:0]    code_sum_ff;
   logic [SQ_W-1:0]     sq_sum_ff, sq_sum_in;
   logic [MS_W-1:0]     ms_cnt_ff;
   logic [MS_W-1:0]     last_cross_ff;
   logic [PERIOD_W-1:0] held_period_ff;
   logic [FREQ_W-1:0]   held_freq_ff;
   logic                present_ff;

   logic [PROD_W-1:0]   mcand_ff;
   logic [SAMPLE_W-1:0] mult_ff;
   logic [BIT_W-1:0]    bit_ff;
   logic                level_ff;

   logic [RMS_W-1:0]    rms_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic [APP_W-1:0]    app_ff;
   logic [PF_W-1:0]     pf_ff;
   logic [DVS_W-1:0]    pf_dvs_ff;

   logic                div_start_ff, div_start_in;
   logic [DIV_W-1:0]    div_dvd_ff;
   logic [DVS_W-1:0]    div_dvs_ff;
   logic                div_done;
   logic [DIV_W-1:0]    div_quot;

   logic                sqrt_start_ff, sqrt_start_in;
   logic [RAD_W-1:0]    sqrt_rad_ff;
   logic                sqrt_done;
   logic [ROOT_W-1:0]   sqrt_root;

   logic                rsp_valid_ff;
   logic [RMS_W-1:0]    rsp_rms_ff;
   logic [MEAN_W-1:0]   rsp_mean_ff;
   logic [APP_W-1:0]    rsp_app_ff;
   logic [PF_W-1:0]     rsp_pf_ff;
   logic [FREQ_W-1:0]   rsp_freq_ff;
   logic [PERIOD_W-1:0] rsp_period_ff;
   logic                rsp_present_ff;
   logic                rsp_relay_ff;

   logic [MS_W-1:0]     elapsed;
   logic                cross_ok;
   logic                out_free;

   acrms_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd_ff),
      .divisor  (div_dvs_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   acrms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (sqrt_rad_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_comb begin
      sq_sum_in = mult_ff[0] ? sq_sum_ff + SQ_W'(mcand_ff) : sq_sum_ff;
      elapsed   = ms_cnt_ff - last_cross_ff;
      cross_ok  = (elapsed != '0) && (elapsed < MS_W'(maxp_ff));
      out_free  = !rsp_valid_ff || rsp.ready;
      // one-cycle start pulses for the divider and the square root
      div_start_in  = ((state_ff == ST_SQUARE) && (bit_ff == BIT_W'(SAMPLE_W - 1))
                       && (frame_idx_ff == IDX_W'(FRAME_SAMPLES)))
                      || (state_ff == ST_MUL)
                      || ((state_ff == ST_DIV_MEAN) && div_done && (rms_ff != '0))
                      || ((state_ff == ST_CROSS) && level_ff && cross_ok);
      sqrt_start_in = (state_ff == ST_DIV_MS) && div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         thresh_ff      <= THRESH_RESET;
         cur_ff         <= CUR_RESET;
         maxp_ff        <= MAXP_RESET;
         frame_idx_ff   <= '0;
         code_sum_ff    <= '0;
         sq_sum_ff      <= '0;
         ms_cnt_ff      <= '0;
         last_cross_ff  <= '0;
         held_period_ff <= '0;
         held_freq_ff   <= '0;
         present_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         div_start_ff   <= 1'b0;
         sqrt_start_ff  <= 1'b0;
      end else begin
         div_start_ff  <= div_start_in;
         sqrt_start_ff <= sqrt_start_in;

         if (csr_write_en) begin
            unique case (csr_index)
               CSR_THRESH:     thresh_ff <= csr_wdata[THRESH_W-1:0];
               CSR_CURRENT:    cur_ff    <= csr_wdata[CUR_W-1:0];
               CSR_MAX_PERIOD: maxp_ff   <= csr_wdata[MAXP_W-1:0];
               default: ;
            endcase
         end

         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  if (req.kind == KIND_TICK) begin
                     ms_cnt_ff <= ms_cnt_ff + 1'b1;
                  end else begin
                     code_sum_ff  <= code_sum_ff + SUM_W'(req.sample);
                     frame_idx_ff <= frame_idx_ff + 1'b1;
                     mcand_ff     <= PROD_W'(req.sample);
                     mult_ff      <= req.sample;
                     bit_ff       <= '0;
                     level_ff     <= req.cross_level;
                     state_ff     <= ST_SQUARE;
                  end
               end
            end
            ST_SQUARE: begin
               // shift-add square, one multiplier bit a cycle
               sq_sum_ff <= sq_sum_in;
               mcand_ff  <= {mcand_ff[PROD_W-2:0], 1'b0};
               mult_ff   <= {1'b0, mult_ff[SAMPLE_W-1:1]};
               bit_ff    <= bit_ff + 1'b1;
               if (bit_ff == BIT_W'(SAMPLE_W - 1)) begin
                  if (frame_idx_ff == IDX_W'(FRAME_SAMPLES)) begin
                     div_dvd_ff   <= {sq_sum_in, {RMS_FRAC_SHIFT{1'b0}}};
                     div_dvs_ff   <= DVS_W'(FRAME_SAMPLES);
                     state_ff     <= ST_DIV_MS;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_DIV_MS: begin
               if (div_done) begin
                  sqrt_rad_ff   <= div_quot[RAD_W-1:0];
                  state_ff      <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (sqrt_done) begin
                  rms_ff   <= sqrt_root;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               div_dvd_ff   <= DIV_W'(code_sum_ff) * DIV_W'(cur_ff);
               div_dvs_ff   <= DVS_W'(FRAME_SAMPLES);
               app_ff       <= APP_W'(rms_ff) * APP_W'(cur_ff);
               pf_dvs_ff    <= DVS_W'(FRAME_SAMPLES) * DVS_W'(rms_ff);
               state_ff     <= ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
               if (div_done) begin
                  mean_ff <= div_quot[MEAN_W-1:0];
                  if (rms_ff == '0) begin
                     pf_ff    <= '0;
                     state_ff <= ST_CROSS;
                  end else begin
                     div_dvd_ff   <= {{(DIV_W - SUM_W - PF_SHIFT){1'b0}}, code_sum_ff,
                                      {PF_SHIFT{1'b0}}};
                     div_dvs_ff   <= pf_dvs_ff;
                     state_ff     <= ST_DIV_PF;
                  end
               end
            end
            ST_DIV_PF: begin
               if (div_done) begin
                  // a floored rms can push the ratio just past one
                  pf_ff    <= (div_quot > DIV_W'(PF_MAX)) ? PF_W'(PF_MAX)
                                                          : div_quot[PF_W-1:0];
                  state_ff <= ST_CROSS;
               end
            end
            ST_CROSS: begin
               if (level_ff) begin
                  if (cross_ok) begin
                     held_period_ff <= elapsed[PERIOD_W-1:0];
                     present_ff     <= 1'b1;
                     last_cross_ff  <= ms_cnt_ff;
                     div_dvd_ff     <= DIV_W'(FREQ_SCALE);
                     div_dvs_ff     <= DVS_W'(elapsed[PERIOD_W-1:0]);
                     state_ff       <= ST_DIV_FREQ;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end else begin
                  present_ff <= 1'b0;
                  state_ff   <= ST_OUT;
               end
            end
            ST_DIV_FREQ: begin
               if (div_done) begin
                  held_freq_ff <= div_quot[FREQ_W-1:0];
                  state_ff     <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_rms_ff     <= rms_ff;
                  rsp_mean_ff    <= mean_ff;
                  rsp_app_ff     <= app_ff;
                  rsp_pf_ff      <= pf_ff;
                  rsp_freq_ff    <= held_freq_ff;
                  rsp_period_ff  <= held_period_ff;
                  rsp_present_ff <= present_ff;
                  rsp_relay_ff   <= (rms_ff <= thresh_ff);
                  frame_idx_ff   <= '0;
                  code_sum_ff    <= '0;
                  sq_sum_ff      <= '0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready          = (state_ff == ST_IDLE);
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.rms_voltage    = rsp_rms_ff;
   assign rsp.mean_power     = rsp_mean_ff;
   assign rsp.apparent_power = rsp_app_ff;
   assign rsp.power_factor   = rsp_pf_ff;
   assign rsp.frequency      = rsp_freq_ff;
   assign rsp.period_ms      = rsp_period_ff;
   assign rsp.ac_present     = rsp_present_ff;
   assign rsp.relay_active   = rsp_relay_ff;

endmodule

`default_nettype wire

// ===== sim/ac_line_rms_monitor_checker.sv =====
`timescale 1ns / 1ps

module ac_line_rms_monitor_checker #(
   parameter int FRAME_LEN = acrms_pkg::DEF_FRAME_SAMPLES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   acrms_req_if                                   req,
   acrms_rsp_if                                   rsp,
   input  wire logic                              csr_write_en,
   input  wire logic [acrms_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [acrms_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                     fail_count,
   output int                                     pending_words,
   output int                                     words_checked,
   output int                                     present_words
);
   import acrms_pkg::*;

   typedef struct packed {
      logic [RMS_W-1:0]    rms;
      logic [MEAN_W-1:0]   mean;
      logic [APP_W-1:0]    apparent;
      logic [PF_W-1:0]     pf;
      logic [FREQ_W-1:0]   freq;
      logic [PERIOD_W-1:0] period;
      logic                present;
      logic                relay;
   } reading_type;

   reading_type expected_readings[$];

   // register copies
   logic [THRESH_W-1:0] thresh_cfg;
   logic [CUR_W-1:0]    current_cfg;
   logic [MAXP_W-1:0]   max_period_cfg;

   // predictor state
   int                  samples_in_frame;
   logic [15:0]         acc_codes;
   logic [27:0]         acc_squares;
   logic [MS_W-1:0]     ms_counter;
   logic [MS_W-1:0]     last_cross_ms;
   logic [PERIOD_W-1:0] period_hold;
   logic [FREQ_W-1:0]   freq_hold;
   logic                present_hold;

   initial begin
      fail_count    = 0;
      pending_words = 0;
      words_checked = 0;
      present_words = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic longint unsigned root_of(input longint unsigned x);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         c = r | (longint'(1) << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   // last sample of a frame: work out the reading and update crossing state
   task automatic predict_frame_end(input logic level);
      longint unsigned rms, mean, app, pf, radicand;
      logic [MS_W-1:0] elapsed;
      reading_type r;
      radicand = (longint'(acc_squares) << RMS_FRAC_SHIFT) / FRAME_LEN;
      rms      = root_of(radicand);
      mean     = (longint'(acc_codes) * current_cfg) / FRAME_LEN;
      app      = rms * current_cfg;
      if (rms == 0) begin
         pf = 0;
      end else begin
         pf = (longint'(acc_codes) << PF_SHIFT) / (FRAME_LEN * rms);
         if (pf > PF_MAX) pf = PF_MAX;
      end
      elapsed = ms_counter - last_cross_ms;
      if (level) begin
         if (elapsed != 0 && elapsed < max_period_cfg) begin
            period_hold   = elapsed[PERIOD_W-1:0];
            freq_hold     = FREQ_W'(FREQ_SCALE / elapsed);
            present_hold  = 1'b1;
            last_cross_ms = ms_counter;
         end
      end else begin
         present_hold = 1'b0;
      end
      r.rms      = rms[RMS_W-1:0];
      r.mean     = mean[MEAN_W-1:0];
      r.apparent = app[APP_W-1:0];
      r.pf       = pf[PF_W-1:0];
      r.freq     = freq_hold;
      r.period   = period_hold;
      r.present  = present_hold;
      r.relay    = (rms <= thresh_cfg);
      expected_readings.push_back(r);
      samples_in_frame = 0;
      acc_codes        = '0;
      acc_squares      = '0;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report($sformatf("word %0d %s: got %0d, want %0d", words_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         thresh_cfg       = THRESH_RESET;
         current_cfg      = CUR_RESET;
         max_period_cfg   = MAXP_RESET;
         samples_in_frame = 0;
         acc_codes        = '0;
         acc_squares      = '0;
         ms_counter       = '0;
         last_cross_ms    = '0;
         period_hold      = '0;
         freq_hold        = '0;
         present_hold     = 1'b0;
         expected_readings.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_THRESH:     thresh_cfg     = csr_wdata[THRESH_W-1:0];
               CSR_CURRENT:    current_cfg    = csr_wdata[CUR_W-1:0];
               CSR_MAX_PERIOD: max_period_cfg = csr_wdata[MAXP_W-1:0];
               default: ;
            endcase
         end

         if (rsp.valid && rsp.ready) begin
            if (expected_readings.size() == 0) begin
               report($sformatf("result word %0d arrived with nothing pending", words_checked));
            end else begin
               reading_type want;
               want = expected_readings.pop_front();
               check_field("rms_voltage",    rsp.rms_voltage,    want.rms);
               check_field("mean_power",     rsp.mean_power,     want.mean);
               check_field("apparent_power", rsp.apparent_power, want.apparent);
               check_field("power_factor",   rsp.power_factor,   want.pf);
               check_field("frequency",      rsp.frequency,      want.freq);
               check_field("period_ms",      rsp.period_ms,      want.period);
               check_field("ac_present",     rsp.ac_present,     want.present);
               check_field("relay_active",   rsp.relay_active,   want.relay);
               if (want.present) present_words <= present_words + 1;
            end
            words_checked <= words_checked + 1;
         end

         if (req.valid && req.ready) begin
            if (req.kind == KIND_TICK) begin
               ms_counter = ms_counter + 1'b1;
            end else begin
               acc_codes   = acc_codes + 16'(req.sample);
               acc_squares = acc_squares + 28'(req.sample) * 28'(req.sample);
               samples_in_frame++;
               if (samples_in_frame >= FRAME_LEN) predict_frame_end(req.cross_level);
            end
         end
      end
      pending_words <= expected_readings.size();
   end

endmodule

// ===== sim/ac_line_rms_monitor_unit_tb.sv =====
`timescale 1ns / 1ps

module ac_line_rms_monitor_unit_tb;
   import acrms_pkg::*;

   localparam int FRAME        = DEF_FRAME_SAMPLES;
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 190;
   localparam int PHASE_FRAMES = 6;

   logic clock;
   logic reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count, pending_words, words_checked, present_words;
   int idle_pct, stall_pct;
   int items_sent, ticks_sent, frames_made;
   int cycle_count;

   acrms_req_if req ();
   acrms_rsp_if rsp ();

   ac_line_rms_monitor_unit #(.FRAME_SAMPLES(FRAME)) dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ac_line_rms_monitor_checker #(.FRAME_LEN(FRAME)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .present_words (present_words)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial rsp.ready = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending", cycle_count,
                  pending_words);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic k, input logic [SAMPLE_W-1:0] s, input logic lvl);
      req.valid       <= 1'b1;
      req.kind        <= k;
      req.sample      <= s;
      req.cross_level <= lvl;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if (k == KIND_TICK) ticks_sent++;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [THRESH_W-1:0] thresh, input logic [CUR_W-1:0] amps,
                             input logic [MAXP_W-1:0] max_period);
      write_reg(CSR_THRESH, thresh);
      write_reg(CSR_CURRENT, CSR_DATA_W'(amps));
      write_reg(CSR_MAX_PERIOD, max_period);
      csr_write_en <= 1'b0;
   endtask

   // wait for every pending word, then let the block go quiet
   task automatic settle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one frame of samples with ticks spread among them
   task automatic gen_frame();
      int style, base, pick, ticks_total;
      int slot_ticks [FRAME];
      logic [SAMPLE_W-1:0] s;
      style = $urandom_range(0, 9);
      base  = $urandom_range(0, 4095);
      pick  = $urandom_range(0, 15);
      if (pick == 0) ticks_total = 0;
      else if (pick == 1) ticks_total = $urandom_range(100, 160);
      else if (pick <= 3) ticks_total = $urandom_range(10, 60);
      else ticks_total = $urandom_range(1, 8);
      foreach (slot_ticks[i]) slot_ticks[i] = 0;
      repeat (ticks_total) slot_ticks[$urandom_range(0, FRAME - 1)]++;
      for (int i = 0; i < FRAME; i++) begin
         repeat (slot_ticks[i])
            send_word(KIND_TICK, SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
         case (style)
            0: s = '0;
            1: s = '1;
            2: s = SAMPLE_W'(base);
            // near-constant frames push the power factor past one before saturation
            3: s = SAMPLE_W'((base > 4091) ? base - $urandom_range(0, 3)
                                           : base + $urandom_range(0, 3));
            default: s = SAMPLE_W'($urandom_range(0, 4095));
         endcase
         send_word(KIND_SAMPLE, s,
                   (i == FRAME - 1) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1)));
      end
      frames_made++;
   endtask

   // random items of either kind, knocking frames out of alignment
   task automatic noise_burst();
      repeat ($urandom_range(1, 15))
         send_word(1'($urandom_range(0, 1)), SAMPLE_W'($urandom_range(0, 4095)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic run_phase(input int idle, input int stall);
      int start_items, start_frames;
      idle_pct     = idle;
      stall_pct    = stall;
      start_items  = items_sent;
      start_frames = frames_made;
      while (items_sent - start_items < PHASE_ITEMS || frames_made - start_frames < PHASE_FRAMES)
      begin
         if ($urandom_range(0, 7) == 0) noise_burst();
         gen_frame();
      end
      settle();
   endtask

   initial begin
      cycle_count = 0;
      items_sent  = 0;
      ticks_sent  = 0;
      frames_made = 0;
      idle_pct    = 0;
      stall_pct   = 0;
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.kind        <= KIND_SAMPLE;
      req.sample      <= '0;
      req.cross_level <= 1'b0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_THRESH;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: a tick with its ignored fields at the top, a full-scale frame
      // crossing after one millisecond, then an all-zero frame crossing with no
      // time elapsed (rejected, present held)
      send_word(KIND_TICK, '1, 1'b1);
      for (int i = 0; i < FRAME; i++) send_word(KIND_SAMPLE, '1, 1'b1);
      for (int i = 0; i < FRAME; i++) send_word(KIND_SAMPLE, '0, 1'b1);
      settle();

      set_config(16'd0, 8'd255, 16'd65535);
      run_phase(0, 0);
      set_config(THRESH_W'($urandom_range(30000, 45000)), CUR_W'($urandom_range(0, 255)),
                 MAXP_W'($urandom_range(20, 150)));
      run_phase(72, 0);
      set_config(16'd65535, 8'd0, 16'd1);
      run_phase(0, 72);
      set_config(THRESH_W'($urandom_range(0, 65535)), CUR_W'($urandom_range(0, 255)),
                 MAXP_W'($urandom_range(2, 100)));
      run_phase(18, 18);

      $display("sent %0d words (%0d ticks, %0d generated frames) over five config settings",
               items_sent, ticks_sent, frames_made);
      $display("checked %0d result words, %0d with ac present", words_checked, present_words);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/acrms_pkg.sv
sv/acrms_if.sv
sv/acrms_div.sv
sv/acrms_sqrt.sv
sv/ac_line_rms_monitor_unit.sv
sim/ac_line_rms_monitor_checker.sv
sim/ac_line_rms_monitor_unit_tb.sv
